// ----- src/vssp_pkg.sv -----
// ============================================================================
// vssp_pkg
// Shared types and constants for the variable speed sample player.
// ============================================================================
package vssp_pkg;

    // Request codes carried by req_type
    localparam logic [2:0] REQ_LOAD  = 3'd0;
    localparam logic [2:0] REQ_TICK  = 3'd1;
    localparam logic [2:0] REQ_PLAY  = 3'd2;
    localparam logic [2:0] REQ_STOP  = 3'd3;
    localparam logic [2:0] REQ_PAUSE = 3'd4;

    // Configuration register indexes
    localparam logic [1:0] CFG_SPEED = 2'd0;
    localparam logic [1:0] CFG_LOOP  = 2'd1;
    localparam logic [1:0] CFG_COUNT = 2'd2;

    localparam int SPEED_W   = 21;
    localparam int COUNT_W   = 17;
    localparam int SAMPLE_W  = 16;
    localparam int ADDR_IN_W = 16;

    localparam logic signed [SPEED_W-1:0] SPEED_RESET = 21'sd65536;

    typedef struct packed {
        logic signed [SPEED_W-1:0] speed;
        logic                      loop_en;
        logic [COUNT_W-1:0]        count;
    } vssp_cfg_t;

    // Per-item status handed from the front end to the back end
    typedef struct packed {
        logic audible;   // tick that produces an interpolated sample
        logic playing;   // playing flag after the item
        logic looped;    // tick wrapped the position
    } vssp_flags_t;

endpackage

// ----- src/variable_speed_sample_player.sv -----
// ============================================================================
// variable_speed_sample_player
// Sample store playback at a signed fixed-point speed with linear
// interpolation between neighboring samples.
// ============================================================================
// One item is taken per clock cycle, back to back, while in_ready is high,
// and every item gives exactly one result item, in order. The accepting
// edge updates the play state and registers the two sample store reads.
// The read data then lands in the queue, the next register holds the
// (b - a) * fraction multiply, and the rounded sum goes into the output
// register. A four-entry queue sits between the front and back ends.
// in_ready drops only when the queue plus the item in flight would fill it.
// With the output stalled, the block takes six items before the input side
// waits: four in the queue, one in the multiply stage and one in the output
// register. The sample store is a 2^ADDR_BITS x 16 RAM with one write and two
// read ports. Load word requests write it. Ticks read the sample at
// floor(position) and its neighbor, both clamped to the last valid sample.
// The store has no reset and needs no clearing pass: entries are defined once
// loaded. Configuration writes (speed, loop_enable, sample_count) take effect
// at the next item.
// ============================================================================
module variable_speed_sample_player #(
    parameter int ADDR_BITS = 16,
    parameter int FRAC_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration write port
    input  logic                                cfg_we,
    input  logic [1:0]                          cfg_index,
    input  logic [vssp_pkg::SPEED_W-1:0]        cfg_data,
    // input item channel
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [2:0]                          req_type,
    input  logic [vssp_pkg::ADDR_IN_W-1:0]      address,
    input  logic signed [vssp_pkg::SAMPLE_W-1:0] sample_data,
    input  logic                                pause_value,
    // result item channel
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [vssp_pkg::SAMPLE_W-1:0] sample_out,
    output logic                                playing,
    output logic                                looped
);

    localparam int Q_DEPTH = 4;
    localparam int CNT_W   = $clog2(Q_DEPTH + 1);
    localparam int SW      = vssp_pkg::SAMPLE_W;
    localparam int FL_W    = $bits(vssp_pkg::vssp_flags_t);
    localparam int Q_W     = FRAC_BITS + 2 * SW + FL_W;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    vssp_pkg::vssp_cfg_t cfg_reg, cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                vssp_pkg::CFG_SPEED: cfg_next.speed   = cfg_data;
                vssp_pkg::CFG_LOOP:  cfg_next.loop_en = cfg_data[0];
                vssp_pkg::CFG_COUNT: cfg_next.count   = cfg_data[vssp_pkg::COUNT_W-1:0];
                default:             cfg_next         = cfg_reg;  // unused index
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{speed: vssp_pkg::SPEED_RESET, loop_en: 1'b0, count: '0};
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // ------------------------------------------------------------------
    // Front end: play state, classification, store access
    // ------------------------------------------------------------------
    logic                  q_push;
    logic [FRAC_BITS-1:0]  push_frac;
    logic [SW-1:0]         push_a, push_b;
    vssp_pkg::vssp_flags_t push_flags;
    logic [CNT_W-1:0]      q_count;

    vssp_front #(
        .ADDR_BITS (ADDR_BITS),
        .FRAC_BITS (FRAC_BITS),
        .Q_DEPTH   (Q_DEPTH)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .req_type    (req_type),
        .address     (address),
        .sample_data (sample_data),
        .pause_value (pause_value),
        .q_count     (q_count),
        .push_valid  (q_push),
        .push_frac   (push_frac),
        .push_a      (push_a),
        .push_b      (push_b),
        .push_flags  (push_flags)
    );

    // ------------------------------------------------------------------
    // Queue between the two halves
    // ------------------------------------------------------------------
    logic [Q_W-1:0]        q_din, q_dout;
    logic                  q_pop, q_empty;
    logic [FRAC_BITS-1:0]  pop_frac;
    logic [SW-1:0]         pop_a, pop_b;
    vssp_pkg::vssp_flags_t pop_flags;

    assign q_din = {push_frac, push_a, push_b, push_flags};
    assign {pop_frac, pop_a, pop_b, pop_flags} = q_dout;

    vssp_queue #(
        .WIDTH (Q_W),
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .din   (q_din),
        .pop   (q_pop),
        .dout  (q_dout),
        .empty (q_empty),
        .count (q_count)
    );

    // ------------------------------------------------------------------
    // Back end: interpolation and output register
    // ------------------------------------------------------------------
    vssp_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .q_pop      (q_pop),
        .frac       (pop_frac),
        .a          (pop_a),
        .b          (pop_b),
        .flags      (pop_flags),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .sample_out (sample_out),
        .playing    (playing),
        .looped     (looped)
    );

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // front end flow control must never let the queue overrun
    assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> (q_count < CNT_W'(Q_DEPTH)))
        else $error("queue push while full");

    // a wrap only happens while looping, so playing stays set
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && looped) |-> playing)
        else $error("looped item without playing");

    // sound only comes out while playing
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && sample_out != '0) |-> playing)
        else $error("nonzero sample while not playing");

endmodule

// ----- src/vssp_ram.sv -----
// ============================================================================
// vssp_ram
// Generic RAM: one write port, two read ports, registered read data.
// ============================================================================
module vssp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_a_reg;
    logic [WIDTH-1:0] rdata_b_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_a_reg <= mem_reg[raddr_a];
            rdata_b_reg <= mem_reg[raddr_b];
        end
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

// ----- src/vssp_front.sv -----
// ============================================================================
// vssp_front
// Front end: accepts items, keeps the play state, issues sample store reads.
// ============================================================================
module vssp_front #(
    parameter int ADDR_BITS = 16,
    parameter int FRAC_BITS = 16,
    parameter int Q_DEPTH   = 4
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  vssp_pkg::vssp_cfg_t                 cfg,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [2:0]                          req_type,
    input  logic [vssp_pkg::ADDR_IN_W-1:0]      address,
    input  logic [vssp_pkg::SAMPLE_W-1:0]       sample_data,
    input  logic                                pause_value,
    input  logic [$clog2(Q_DEPTH+1)-1:0]        q_count,
    output logic                                push_valid,
    output logic [FRAC_BITS-1:0]                push_frac,
    output logic [vssp_pkg::SAMPLE_W-1:0]       push_a,
    output logic [vssp_pkg::SAMPLE_W-1:0]       push_b,
    output vssp_pkg::vssp_flags_t               push_flags
);

    localparam int DEPTH   = 1 << ADDR_BITS;
    localparam int LEN_W   = ADDR_BITS + 1;
    localparam int CW      = (vssp_pkg::COUNT_W > LEN_W) ? vssp_pkg::COUNT_W : LEN_W;
    localparam int MAG_W   = (ADDR_BITS + FRAC_BITS > vssp_pkg::SPEED_W)
                             ? ADDR_BITS + FRAC_BITS : vssp_pkg::SPEED_W;
    localparam int POS_W   = MAG_W + 2;
    localparam int IP_W    = POS_W - FRAC_BITS;
    localparam int AX_W    = (vssp_pkg::ADDR_IN_W > ADDR_BITS) ? vssp_pkg::ADDR_IN_W : ADDR_BITS;
    localparam int CNT_W   = $clog2(Q_DEPTH + 1);

    logic signed [POS_W-1:0] pos_reg, pos_next;
    logic                    playing_reg, playing_next;
    logic                    paused_reg, paused_next;
    logic                    s1_valid_reg;
    logic [FRAC_BITS-1:0]    s1_frac_reg;
    vssp_pkg::vssp_flags_t   s1_flags_reg;

    logic                    accept;
    logic [CW-1:0]           count_ext;
    logic [CW-1:0]           depth_ext;
    logic [LEN_W-1:0]        len;
    logic [LEN_W-1:0]        len_m1;
    logic signed [POS_W-1:0] len_pos;
    logic signed [POS_W-1:0] speed_ext;
    logic signed [POS_W-1:0] sum;
    logic signed [IP_W-1:0]  p_int;
    logic signed [IP_W-1:0]  len_ip;
    logic                    over, under, active;
    logic                    wrapped, audible;
    logic [LEN_W-1:0]        pp, pp1, ia, ib;
    logic [AX_W-1:0]         addr_ext;

    assign accept    = in_valid && in_ready;
    assign in_ready  = ({1'b0, q_count} + (CNT_W+1)'(s1_valid_reg))
                       < (CNT_W+1)'(Q_DEPTH);

    // Effective length: sample count saturated to the store depth
    assign count_ext = CW'(cfg.count);
    assign depth_ext = CW'(DEPTH);
    assign len       = (count_ext > depth_ext) ? depth_ext[LEN_W-1:0] : count_ext[LEN_W-1:0];
    assign len_m1    = len - LEN_W'(1);
    assign len_pos   = $signed({{(POS_W-LEN_W-FRAC_BITS){1'b0}}, len, {FRAC_BITS{1'b0}}});
    assign speed_ext = $signed({{(POS_W-vssp_pkg::SPEED_W){cfg.speed[vssp_pkg::SPEED_W-1]}},
                                cfg.speed});

    assign sum    = pos_reg + speed_ext;
    assign p_int  = sum[POS_W-1:FRAC_BITS];
    assign len_ip = $signed({{(IP_W-LEN_W){1'b0}}, len});
    assign over   = p_int > len_ip;
    assign under  = sum[POS_W-1];
    assign active = playing_reg && !paused_reg && (len != '0);

    always_comb
    begin
        pos_next     = pos_reg;
        playing_next = playing_reg;
        paused_next  = paused_reg;
        wrapped      = 1'b0;
        audible      = 1'b0;
        if (accept)
        begin
            case (req_type)
                vssp_pkg::REQ_TICK:
                begin
                    if (active)
                    begin
                        pos_next = sum;
                        audible  = 1'b1;
                        if (over || under)
                        begin
                            if (cfg.loop_en)
                            begin
                                pos_next = under ? len_pos : '0;
                                wrapped  = 1'b1;
                            end
                            else
                            begin
                                playing_next = 1'b0;
                                audible      = 1'b0;
                            end
                        end
                    end
                end
                vssp_pkg::REQ_PLAY:
                begin
                    pos_next     = (!cfg.speed[vssp_pkg::SPEED_W-1] && cfg.speed != '0)
                                   ? '0 : len_pos;
                    playing_next = 1'b1;
                end
                vssp_pkg::REQ_STOP:
                begin
                    pos_next     = '0;
                    playing_next = 1'b0;
                    paused_next  = 1'b0;
                end
                vssp_pkg::REQ_PAUSE:
                begin
                    paused_next = pause_value;
                end
                default:
                begin
                    // load word goes to the store; other codes do nothing
                end
            endcase
        end
    end

    // Sample indices; only meaningful when the position is inside [0, len]
    assign pp  = pos_next[FRAC_BITS+LEN_W-1:FRAC_BITS];
    assign pp1 = pp + LEN_W'(1);
    assign ia  = (pp  >= len) ? len_m1 : pp;
    assign ib  = (pp1 >= len) ? len_m1 : pp1;

    assign addr_ext = AX_W'(address);

    vssp_ram #(
        .WIDTH (vssp_pkg::SAMPLE_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (clk),
        .we      (accept && req_type == vssp_pkg::REQ_LOAD),
        .waddr   (addr_ext[ADDR_BITS-1:0]),
        .wdata   (sample_data),
        .re      (accept),
        .raddr_a (ia[ADDR_BITS-1:0]),
        .raddr_b (ib[ADDR_BITS-1:0]),
        .rdata_a (push_a),
        .rdata_b (push_b)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            playing_reg  <= 1'b0;
            paused_reg   <= 1'b0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg      <= pos_next;
            playing_reg  <= playing_next;
            paused_reg   <= paused_next;
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_frac_reg  <= pos_next[FRAC_BITS-1:0];
            s1_flags_reg <= '{audible: audible, playing: playing_next, looped: wrapped};
        end
    end

    assign push_valid = s1_valid_reg;
    assign push_frac  = s1_frac_reg;
    assign push_flags = s1_flags_reg;

endmodule

// ----- src/vssp_queue.sv -----
// ============================================================================
// vssp_queue
// Small register FIFO between the front and back ends.
// ============================================================================
module vssp_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  logic [WIDTH-1:0]           din,
    input  logic                       pop,
    output logic [WIDTH-1:0]           dout,
    output logic                       empty,
    output logic [$clog2(DEPTH+1)-1:0] count
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_pop;

    assign do_pop = pop && (count_reg != '0);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (!push && do_pop)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

    assign dout  = mem_reg[rd_ptr_reg];
    assign empty = (count_reg == '0);
    assign count = count_reg;

endmodule

// ----- src/vssp_back.sv -----
// ============================================================================
// vssp_back
// Back end: linear interpolation (a registered multiply stage, then rounding
// into the output register).
// ============================================================================
module vssp_back #(
    parameter int FRAC_BITS = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           q_empty,
    output logic                           q_pop,
    input  logic [FRAC_BITS-1:0]           frac,
    input  logic [vssp_pkg::SAMPLE_W-1:0]  a,
    input  logic [vssp_pkg::SAMPLE_W-1:0]  b,
    input  vssp_pkg::vssp_flags_t          flags,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [vssp_pkg::SAMPLE_W-1:0]  sample_out,
    output logic                           playing,
    output logic                           looped
);

    localparam int SW     = vssp_pkg::SAMPLE_W;
    localparam int PROD_W = SW + FRAC_BITS + 2;
    localparam int RES_W  = PROD_W - FRAC_BITS;

    logic                     p_valid_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic [SW-1:0]            p_a_reg;
    vssp_pkg::vssp_flags_t    p_flags_reg;

    logic                     o_valid_reg;
    logic [SW-1:0]            o_sample_reg;
    logic                     o_playing_reg;
    logic                     o_looped_reg;

    logic                     adv_o, adv_p;
    logic signed [SW:0]       diff;
    logic signed [PROD_W-1:0] diff_ext, frac_ext, prod;
    logic signed [PROD_W-1:0] rounded;
    logic signed [RES_W-1:0]  res;

    assign adv_o = !o_valid_reg || out_ready;
    assign adv_p = !p_valid_reg || adv_o;
    assign q_pop = !q_empty && adv_p;

    // (b - a) * frac, registered before the rounding add
    assign diff     = $signed({b[SW-1], b}) - $signed({a[SW-1], a});
    assign diff_ext = $signed({{(PROD_W-SW-1){diff[SW]}}, diff});
    assign frac_ext = $signed({{(PROD_W-FRAC_BITS){1'b0}}, frac});
    assign prod     = diff_ext * frac_ext;

    // round half up, floor shift, add the base sample
    assign rounded = prod_reg + $signed({{(PROD_W-FRAC_BITS){1'b0}}, 1'b1,
                                         {(FRAC_BITS-1){1'b0}}});
    assign res     = rounded[PROD_W-1:FRAC_BITS]
                     + $signed({{(RES_W-SW){p_a_reg[SW-1]}}, p_a_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv_p)
            begin
                p_valid_reg <= q_pop;
            end
            if (adv_o)
            begin
                o_valid_reg <= p_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            prod_reg    <= prod;
            p_a_reg     <= a;
            p_flags_reg <= flags;
        end
        if (adv_o && p_valid_reg)
        begin
            o_sample_reg  <= p_flags_reg.audible ? res[SW-1:0] : '0;
            o_playing_reg <= p_flags_reg.playing;
            o_looped_reg  <= p_flags_reg.looped;
        end
    end

    assign out_valid  = o_valid_reg;
    assign sample_out = o_sample_reg;
    assign playing    = o_playing_reg;
    assign looped     = o_looped_reg;

endmodule

// ----- tb/sv/variable_speed_sample_player_tb.sv -----
`timescale 1ns / 100ps
// ============================================================================
// variable_speed_sample_player_tb
// Self-checking bench for the sample player. It keeps its own copy of the
// sample store and the play state. Every accepted request item is predicted
// on the spot, and each result item is checked field by field, in order.
// Traffic runs in phases: directed corners first (clamping, stopping, wraps
// at both ends, pause, odd codes and register extremes), then random play
// sessions under several idle/stall mixes, then a long output hold-off.
// ============================================================================
module variable_speed_sample_player_tb;

    localparam int      FRAC_BITS       = 16;
    localparam longint  STORE_DEPTH     = 65536;
    localparam longint  UNIT_SPEED      = 65536;          // 1.0 in speed units
    localparam longint  SPEED_MIN       = -1048576;       // full 21-bit range
    localparam longint  SPEED_MAX       = 1048575;
    localparam int      COUNT_MAX       = 131071;         // saturates to depth
    localparam int      CYCLE_LIMIT     = 400000;
    localparam int      HOLD_OFF_CYCLES = 300;
    localparam int      SETTLE_CYCLES   = 8;
    localparam int      SESSION_ITEMS   = 38;
    localparam int      MAX_REPORTS     = 10;

    localparam logic [2:0] REQ_FIRST_UNUSED = 3'd5;
    localparam logic [2:0] REQ_LAST_CODE    = 3'd7;
    localparam logic [1:0] CFG_UNUSED       = 2'd3;

    localparam logic signed [vssp_pkg::SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;
    localparam logic signed [vssp_pkg::SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7fff;

    typedef struct packed {
        logic signed [vssp_pkg::SAMPLE_W-1:0] sample;
        logic                                 playing;
        logic                                 looped;
    } player_result_t;

    // ------------------------------------------------------------------------
    // DUT hookup; every input starts at a known value
    // ------------------------------------------------------------------------
    logic                                 clk         = 1'b0;
    logic                                 rst_n       = 1'b0;
    logic                                 cfg_we      = 1'b0;
    logic [1:0]                           cfg_index   = '0;
    logic [vssp_pkg::SPEED_W-1:0]         cfg_data    = '0;
    logic                                 in_valid    = 1'b0;
    logic                                 in_ready;
    logic [2:0]                           req_type    = '0;
    logic [vssp_pkg::ADDR_IN_W-1:0]       address     = '0;
    logic signed [vssp_pkg::SAMPLE_W-1:0] sample_data = '0;
    logic                                 pause_value = 1'b0;
    logic                                 out_valid;
    logic                                 out_ready   = 1'b0;
    logic signed [vssp_pkg::SAMPLE_W-1:0] sample_out;
    logic                                 playing;
    logic                                 looped;

    variable_speed_sample_player uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .req_type    (req_type),
        .address     (address),
        .sample_data (sample_data),
        .pause_value (pause_value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .sample_out  (sample_out),
        .playing     (playing),
        .looped      (looped)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Shadow player state, starts at reset values
    // ------------------------------------------------------------------------
    logic signed [vssp_pkg::SAMPLE_W-1:0] shadow_samples [STORE_DEPTH];
    bit                                   sample_loaded  [STORE_DEPTH];
    longint                               play_pos   = 0;
    bit                                   play_on    = 1'b0;
    bit                                   pause_on   = 1'b0;
    longint                               play_speed = UNIT_SPEED;
    bit                                   play_loop  = 1'b0;
    logic [vssp_pkg::COUNT_W-1:0]         play_count = '0;

    player_result_t pending_results [$];
    int             mismatch_count = 0;
    int             send_idle_pct  = 0;
    int             recv_stall_pct = 0;
    int             hold_off_left  = 0;
    int unsigned    cycle_count    = 0;

    function automatic longint play_length();
        return (longint'(play_count) > STORE_DEPTH) ? STORE_DEPTH : longint'(play_count);
    endfunction

    function automatic bit tick_audible();
        return play_on && !pause_on && play_length() != 0;
    endfunction

    function automatic int clamp_index(input longint idx, input longint len);
        if (idx < 0)
            idx = 0;
        if (idx > len - 1)
            idx = len - 1;
        return int'(idx);
    endfunction

    // Position after one audible tick; does not touch the state.
    // On a stop the position keeps the added step.
    function automatic void advance_position(output longint next_pos, output bit wrapped,
                                             output bit halted);
        longint len;
        longint whole;
        len      = play_length();
        next_pos = play_pos + play_speed;
        whole    = next_pos >>> FRAC_BITS;
        wrapped  = 1'b0;
        halted   = 1'b0;
        if (whole > len || whole < 0)
        begin
            if (play_loop)
            begin
                next_pos = (whole > len) ? 0 : (len <<< FRAC_BITS);
                wrapped  = 1'b1;
            end
            else
                halted = 1'b1;
        end
    endfunction

    // Linear blend of the two neighbors, round half up
    function automatic logic signed [vssp_pkg::SAMPLE_W-1:0] interpolate(input longint at);
        longint len;
        longint whole;
        longint frac;
        longint a;
        longint b;
        len   = play_length();
        whole = at >>> FRAC_BITS;
        frac  = at - (whole <<< FRAC_BITS);
        a     = shadow_samples[clamp_index(whole, len)];
        b     = shadow_samples[clamp_index(whole + 1, len)];
        return 16'(a + (((b - a) * frac + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS));
    endfunction

    function automatic void predict_player(input logic [2:0] req, input logic [15:0] addr,
                                           input logic signed [15:0] data, input logic pv);
        player_result_t res;
        longint         next_pos;
        bit             wrapped;
        bit             halted;
        res = '0;
        case (req)
            vssp_pkg::REQ_LOAD:
            begin
                shadow_samples[addr] = data;
                sample_loaded[addr]  = 1'b1;
            end
            vssp_pkg::REQ_TICK:
            begin
                if (tick_audible())
                begin
                    advance_position(next_pos, wrapped, halted);
                    play_pos = next_pos;
                    if (halted)
                        play_on = 1'b0;
                    else
                    begin
                        res.looped = wrapped;
                        res.sample = interpolate(play_pos);
                    end
                end
            end
            vssp_pkg::REQ_PLAY:
            begin
                play_pos = (play_speed > 0) ? 0 : (play_length() <<< FRAC_BITS);
                play_on  = 1'b1;
            end
            vssp_pkg::REQ_STOP:
            begin
                play_pos = 0;
                pause_on = 1'b0;
                play_on  = 1'b0;
            end
            vssp_pkg::REQ_PAUSE:
                pause_on = pv;
            default:
                ;
        endcase
        res.playing = play_on;
        pending_results.insert(pending_results.size(), res);
    endfunction

    // ------------------------------------------------------------------------
    // Driving
    // ------------------------------------------------------------------------

    // Offer one item and hold it until taken; in_valid stays high on return
    task automatic send_item(input logic [2:0] req, input logic [15:0] addr,
                             input logic signed [15:0] data, input logic pv);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        req_type    <= req;
        address     <= addr;
        sample_data <= data;
        pause_value <= pv;
        do
            @(posedge clk);
        while (in_ready !== 1'b1);
        predict_player(req, addr, data, pv);
    endtask

    // A tick must never read a never-written entry: load the two samples
    // it is going to touch first if needed
    task automatic preload_tick_reads();
        longint next_pos;
        longint whole;
        longint len;
        bit     wrapped;
        bit     halted;
        int     idx [2];
        if (!tick_audible())
            return;
        advance_position(next_pos, wrapped, halted);
        if (halted)
            return;
        len    = play_length();
        whole  = next_pos >>> FRAC_BITS;
        idx[0] = clamp_index(whole, len);
        idx[1] = clamp_index(whole + 1, len);
        foreach (idx[k])
            if (!sample_loaded[idx[k]])
                send_item(vssp_pkg::REQ_LOAD, idx[k][15:0], 16'($urandom), 1'($urandom));
    endtask

    task automatic issue(input logic [2:0] req, input logic [15:0] addr,
                         input logic signed [15:0] data, input logic pv);
        if (req == vssp_pkg::REQ_TICK)
            preload_tick_reads();
        send_item(req, addr, data, pv);
    endtask

    // Request with random don't-care fields; loads favor the low addresses
    task automatic op(input logic [2:0] req);
        logic [15:0] addr;
        addr = $urandom_range(1) ? 16'($urandom_range(31)) : 16'($urandom);
        issue(req, addr, 16'($urandom), $urandom_range(99) < 30);
    endtask

    // Sender goes quiet until every result is back, then a few more cycles
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes all registers plus the unused index; upper data bits are noise
    task automatic configure(input longint spd, input bit lp, input int unsigned cnt);
        cfg_we    <= 1'b1;
        cfg_index <= vssp_pkg::CFG_SPEED;
        cfg_data  <= spd[vssp_pkg::SPEED_W-1:0];
        @(posedge clk);
        cfg_index <= vssp_pkg::CFG_LOOP;
        cfg_data  <= {20'($urandom), lp};
        @(posedge clk);
        cfg_index <= vssp_pkg::CFG_COUNT;
        cfg_data  <= {4'($urandom), cnt[vssp_pkg::COUNT_W-1:0]};
        @(posedge clk);
        cfg_index <= CFG_UNUSED;
        cfg_data  <= 21'($urandom);
        @(posedge clk);
        cfg_we     <= 1'b0;
        play_speed = longint'($signed(spd[vssp_pkg::SPEED_W-1:0]));
        play_loop  = lp;
        play_count = cnt[vssp_pkg::COUNT_W-1:0];
    endtask

    function automatic longint random_speed();
        longint mag;
        if ($urandom_range(7) == 0)
        begin
            case ($urandom_range(2))
                0:       return SPEED_MIN;
                1:       return SPEED_MAX;
                default: return 0;
            endcase
        end
        mag = $urandom_range(1, 3 * UNIT_SPEED);
        return $urandom_range(1) ? -mag : mag;
    endfunction

    function automatic int unsigned random_count();
        case ($urandom_range(9))
            0:       return 0;
            1:       return $urandom_range(STORE_DEPTH, COUNT_MAX);
            default: return $urandom_range(1, 24);
        endcase
    endfunction

    task automatic random_item();
        int pick;
        pick = $urandom_range(99);
        if (pick < 58)
            op(vssp_pkg::REQ_TICK);
        else if (pick < 70)
            op(vssp_pkg::REQ_LOAD);
        else if (pick < 78)
            op(vssp_pkg::REQ_PLAY);
        else if (pick < 82)
            op(vssp_pkg::REQ_STOP);
        else if (pick < 94)
            op(vssp_pkg::REQ_PAUSE);
        else
            op(3'($urandom_range(REQ_LAST_CODE, REQ_FIRST_UNUSED)));
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Reset defaults: sample count is zero, so every tick is silent
    task automatic test_idle_requests();
        op(vssp_pkg::REQ_TICK);              // not playing yet
        op(vssp_pkg::REQ_PLAY);
        op(vssp_pkg::REQ_TICK);              // playing but empty
        issue(vssp_pkg::REQ_PAUSE, '0, '0, 1'b1);
        issue(vssp_pkg::REQ_PAUSE, '0, '0, 1'b0);
        op(REQ_FIRST_UNUSED);
        op(REQ_LAST_CODE);
        issue(vssp_pkg::REQ_LOAD, 16'hffff, SAMPLE_MAX, 1'b1);
        op(vssp_pkg::REQ_STOP);
        wait_idle();
    endtask

    // Half speed over three samples: full-scale swing, rounding of halves,
    // clamp at the last sample, pause, then running off the end
    task automatic test_forward_clamp_stop();
        configure(UNIT_SPEED / 2, 1'b0, 3);
        issue(vssp_pkg::REQ_LOAD, 16'd0, SAMPLE_MIN, 1'b0);
        issue(vssp_pkg::REQ_LOAD, 16'd1, SAMPLE_MAX, 1'b1);
        issue(vssp_pkg::REQ_LOAD, 16'd2, 16'sd1, 1'b0);
        op(vssp_pkg::REQ_PLAY);
        repeat (3) op(vssp_pkg::REQ_TICK);
        issue(vssp_pkg::REQ_PAUSE, '0, '0, 1'b1);
        op(vssp_pkg::REQ_TICK);              // paused: silent
        issue(vssp_pkg::REQ_PAUSE, '0, '0, 1'b0);
        repeat (6) op(vssp_pkg::REQ_TICK);
        wait_idle();
    endtask

    // Reverse with looping wraps to the full length; then stop
    task automatic test_reverse_loop();
        configure(-(3 * UNIT_SPEED / 4), 1'b1, 3);
        op(vssp_pkg::REQ_PLAY);
        repeat (8) op(vssp_pkg::REQ_TICK);
        op(vssp_pkg::REQ_STOP);
        op(vssp_pkg::REQ_TICK);
        wait_idle();
    endtask

    // Big step wrapping forward, zero speed parking at the end,
    // and reverse without looping falling off the start
    task automatic test_speed_corners();
        configure(8 * UNIT_SPEED, 1'b1, 3);
        op(vssp_pkg::REQ_PLAY);
        repeat (3) op(vssp_pkg::REQ_TICK);
        wait_idle();
        configure(0, 1'b0, 3);
        op(vssp_pkg::REQ_PLAY);
        repeat (2) op(vssp_pkg::REQ_TICK);
        wait_idle();
        configure(-UNIT_SPEED, 1'b0, 3);
        op(vssp_pkg::REQ_PLAY);
        repeat (5) op(vssp_pkg::REQ_TICK);
        wait_idle();
    endtask

    // Register extremes: full store, oversize count, widest speeds, one sample
    task automatic test_register_extremes();
        configure(SPEED_MIN, 1'b1, COUNT_MAX);
        op(vssp_pkg::REQ_PLAY);
        repeat (4) op(vssp_pkg::REQ_TICK);
        wait_idle();
        configure(SPEED_MAX, 1'b0, STORE_DEPTH);
        op(vssp_pkg::REQ_PLAY);
        repeat (4) op(vssp_pkg::REQ_TICK);
        wait_idle();
        configure(1, 1'b1, 1);
        op(vssp_pkg::REQ_PLAY);
        repeat (3) op(vssp_pkg::REQ_TICK);
        wait_idle();
    endtask

    // Play sessions with fresh settings each time
    task automatic test_random_sessions(input int idle_pct, input int stall_pct, input int total);
        int sent;
        sent           = 0;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        while (sent < total)
        begin
            wait_idle();
            configure(random_speed(), 1'($urandom_range(1)), random_count());
            op(vssp_pkg::REQ_PLAY);
            repeat (SESSION_ITEMS) random_item();
            sent += SESSION_ITEMS + 1;
        end
        wait_idle();
    endtask

    // Output held off while the sender keeps offering, so the block fills
    // and drops in_ready; then the sender pauses for a full drain mid-stream
    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        configure(UNIT_SPEED / 4, 1'b1, 8);
        op(vssp_pkg::REQ_PLAY);
        hold_off_left = HOLD_OFF_CYCLES;
        repeat (40) op(vssp_pkg::REQ_TICK);
        wait_idle();
        repeat (20) random_item();
        wait_idle();
    endtask

    // ------------------------------------------------------------------------
    // Receiver: random stalls, or a counted hold-off when one is armed
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (hold_off_left > 0)
        begin
            out_ready     <= 1'b0;
            hold_off_left <= hold_off_left - 1;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic note_mismatch(input string what, input longint want, input longint got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("[%0t] %s: expected %0d, got %0d", $time, what, want, got);
    endtask

    // Result checker, in order against the oldest prediction
    always @(posedge clk)
    begin : result_check
        player_result_t want;
        if (rst_n && out_valid === 1'b1 && out_ready)
        begin
            if (pending_results.size() == 0)
                note_mismatch("result with nothing pending, sample_out", 0, sample_out);
            else
            begin
                want = pending_results.pop_front();
                if (sample_out !== want.sample)
                    note_mismatch("sample_out", want.sample, sample_out);
                if (playing !== want.playing)
                    note_mismatch("playing", want.playing, playing);
                if (looped !== want.looped)
                    note_mismatch("looped", want.looped, looped);
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_idle_requests();
        test_forward_clamp_stop();
        test_reverse_loop();
        test_speed_corners();
        test_register_extremes();

        test_random_sessions(0, 0, 150);
        test_random_sessions(77, 0, 150);
        test_random_sessions(0, 77, 150);
        test_random_sessions(6, 6, 150);

        test_backpressure();

        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
